// File: hdl/dbdf_pkg.sv
// Package for the detection box decode filter: types, constants and the box axis function.
package dbdf_pkg;

    localparam int SCORE_W     = 16;
    localparam int COORD_W     = 16;
    localparam int PAD_W       = 12;
    localparam int FRAME_W     = 13;
    localparam int PIX_W       = 12;
    localparam int NUM_CLASSES = 4;
    localparam int CLASS_W     = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [FRAME_W-1:0] FRAME_MAX = 13'd4096;

    localparam logic [SCORE_W-1:0] RST_THRESHOLD = 16'd16384;
    localparam logic [PAD_W-1:0]   RST_PAD       = 12'd0;
    localparam logic [FRAME_W-1:0] RST_FRAME     = 13'd640;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCORE_THRESHOLD = 3'd0,
        CFG_PAD_LEFT        = 3'd1,
        CFG_PAD_TOP         = 3'd2,
        CFG_FRAME_WIDTH     = 3'd3,
        CFG_FRAME_HEIGHT    = 3'd4
    } t_cfg_idx;

    typedef logic [SCORE_W-1:0] t_scores [NUM_CLASSES];

    typedef struct packed {
        logic             ok;
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] span;
        logic [PIX_W-1:0] mid;
    } t_axis;

    // Corner pair along one axis, worked in Q.5 so that half the size is exact.
    function automatic t_axis box_axis(
        input logic        [COORD_W-1:0] centre,
        input logic        [COORD_W-1:0] size,
        input logic signed [PAD_W-1:0]   pad,
        input logic        [FRAME_W-1:0] frame
    );
        t_axis               res;
        logic signed [19:0]  c;
        logic signed [19:0]  lo_sum;
        logic signed [19:0]  hi_sum;
        logic        [13:0]  a;
        logic        [FRAME_W-1:0] frame_c;
        logic signed [14:0]  bound;
        logic signed [14:0]  hi_q;
        logic signed [14:0]  a_s;
        logic signed [14:0]  bmin;
        logic signed [14:0]  span;
        c       = $signed({3'b000, centre, 1'b0}) - $signed({{3{pad[PAD_W-1]}}, pad, 5'b00000});
        lo_sum  = c - $signed({4'b0000, size});
        hi_sum  = c + $signed({4'b0000, size});
        // negative low corner truncates toward zero and clamps to zero
        a       = lo_sum[19] ? 14'd0 : lo_sum[18:5];
        frame_c = (frame > FRAME_MAX) ? FRAME_MAX : frame;
        bound   = $signed({2'b00, frame_c}) - 15'sd1;
        hi_q    = $signed({1'b0, hi_sum[18:5]});
        a_s     = $signed({1'b0, a});
        bmin    = (hi_q > bound) ? bound : hi_q;
        span    = bmin - a_s;
        // negative high corner is never above the clamped low corner
        res.ok   = !hi_sum[19] && (bmin > a_s);
        res.lo   = a[PIX_W-1:0];
        res.span = span[PIX_W-1:0];
        res.mid  = a[PIX_W-1:0] + {1'b0, span[PIX_W-1:1]};
        return res;
    endfunction

endpackage

// File: hdl/detection_box_decode_filter.sv
// Detection box decode and threshold filter, top level.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one raw detection per item: centre,
//   size (Q12.4), objectness and four class scores (Q0.16).
//   Output channel (o_valid/i_ready) carries one result item per input item:
//   keep flag, class, confidence, clamped corner, span and mid point. When keep
//   is low every other result field is zero.
//   Configuration is a write port (i_cfg_we, i_cfg_index, i_cfg_data); write it
//   only while no item is in flight.
// Pipeline: an accepted input item passes the input register, then the result
//   register, which drives the outputs; a low i_ready can hold it between the
//   two. Throughput: one item per cycle while i_ready is high, since each
//   register advances whenever the one after it moves on.
// Reset: synchronous, active low; pipeline empties and the registers return
//   to threshold 0.25, zero padding and a 640x640 frame.
// Stall: when i_ready is low a valid result register holds; the input register
//   still takes an item while it is empty, then o_ready drops.
module detection_box_decode_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_centre_x,
    input  logic [15:0] i_centre_y,
    input  logic [15:0] i_box_w,
    input  logic [15:0] i_box_h,
    input  logic [15:0] i_objectness,
    input  logic [15:0] i_class_score0,
    input  logic [15:0] i_class_score1,
    input  logic [15:0] i_class_score2,
    input  logic [15:0] i_class_score3,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_keep,
    output logic [1:0]  o_class_index,
    output logic [15:0] o_confidence,
    output logic [11:0] o_left_x,
    output logic [11:0] o_top_y,
    output logic [11:0] o_span_w,
    output logic [11:0] o_span_h,
    output logic [11:0] o_mid_x,
    output logic [11:0] o_mid_y
);
    import dbdf_pkg::*;

    logic [SCORE_W-1:0]      r_threshold;
    logic signed [PAD_W-1:0] r_pad_left;
    logic signed [PAD_W-1:0] r_pad_top;
    logic [FRAME_W-1:0]      r_frame_w;
    logic [FRAME_W-1:0]      r_frame_h;

    logic               r_s1_valid;
    logic [COORD_W-1:0] r_cx, r_cy, r_bw, r_bh;
    logic [SCORE_W-1:0] r_obj;
    t_scores            r_cls;

    logic               r_out_valid;
    logic               r_keep;
    logic [CLASS_W-1:0] r_class;
    logic [SCORE_W-1:0] r_conf;
    logic [PIX_W-1:0]   r_left, r_top, r_span_w, r_span_h, r_mid_x, r_mid_y;

    logic               out_adv;
    logic               in_acc;
    logic [SCORE_W-1:0] best;
    logic [CLASS_W-1:0] best_idx;
    logic [31:0]        prod;
    logic [SCORE_W-1:0] conf;
    t_axis              ax_x, ax_y;
    logic               n_keep;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RST_THRESHOLD;
            r_pad_left  <= RST_PAD;
            r_pad_top   <= RST_PAD;
            r_frame_w   <= RST_FRAME;
            r_frame_h   <= RST_FRAME;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SCORE_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_PAD_LEFT:        r_pad_left  <= i_cfg_data[PAD_W-1:0];
                CFG_PAD_TOP:         r_pad_top   <= i_cfg_data[PAD_W-1:0];
                CFG_FRAME_WIDTH:     r_frame_w   <= i_cfg_data[FRAME_W-1:0];
                CFG_FRAME_HEIGHT:    r_frame_h   <= i_cfg_data[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_adv = !r_out_valid || i_ready;
    assign o_ready = !r_s1_valid || out_adv;
    assign in_acc  = i_valid && o_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cx     <= i_centre_x;
            r_cy     <= i_centre_y;
            r_bw     <= i_box_w;
            r_bh     <= i_box_h;
            r_obj    <= i_objectness;
            r_cls[0] <= i_class_score0;
            r_cls[1] <= i_class_score1;
            r_cls[2] <= i_class_score2;
            r_cls[3] <= i_class_score3;
        end
    end

    // first highest class score
    always_comb begin
        best     = r_cls[0];
        best_idx = '0;
        for (int i = 1; i < NUM_CLASSES; i++) begin
            if (r_cls[i] > best) begin
                best     = r_cls[i];
                best_idx = CLASS_W'(i);
            end
        end
    end

    assign prod = {16'b0, r_obj} * {16'b0, best};
    assign conf = prod[31:16];
    assign ax_x = box_axis(r_cx, r_bw, r_pad_left, r_frame_w);
    assign ax_y = box_axis(r_cy, r_bh, r_pad_top, r_frame_h);
    assign n_keep = (r_obj >= r_threshold) && (conf >= r_threshold) && ax_x.ok && ax_y.ok;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_valid) begin
            r_keep   <= n_keep;
            r_class  <= n_keep ? best_idx  : '0;
            r_conf   <= n_keep ? conf      : '0;
            r_left   <= n_keep ? ax_x.lo   : '0;
            r_top    <= n_keep ? ax_y.lo   : '0;
            r_span_w <= n_keep ? ax_x.span : '0;
            r_span_h <= n_keep ? ax_y.span : '0;
            r_mid_x  <= n_keep ? ax_x.mid  : '0;
            r_mid_y  <= n_keep ? ax_y.mid  : '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_keep        = r_keep;
    assign o_class_index = r_class;
    assign o_confidence  = r_conf;
    assign o_left_x      = r_left;
    assign o_top_y       = r_top;
    assign o_span_w      = r_span_w;
    assign o_span_h      = r_span_h;
    assign o_mid_x       = r_mid_x;
    assign o_mid_y       = r_mid_y;

endmodule

// File: hdl/dbdf_checker.sv
// Port-level assertions for the detection box decode filter, bound to the top level.
module dbdf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_keep,
    input logic [1:0]  o_class_index,
    input logic [15:0] o_confidence,
    input logic [11:0] o_left_x,
    input logic [11:0] o_top_y,
    input logic [11:0] o_span_w,
    input logic [11:0] o_span_h,
    input logic [11:0] o_mid_x,
    input logic [11:0] o_mid_y
);

    // stalled result stays valid and keeps its keep flag and confidence
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_keep) && $stable(o_confidence))
        else $error("result changed under stall");

    // dropped item has all fields zero
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_keep |-> o_class_index == 2'd0 && o_confidence == 16'd0 &&
            o_left_x == 12'd0 && o_top_y == 12'd0 && o_span_w == 12'd0 &&
            o_span_h == 12'd0 && o_mid_x == 12'd0 && o_mid_y == 12'd0)
        else $error("dropped item carries data");

    // kept box is nonempty
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_keep |-> o_span_w != 12'd0 && o_span_h != 12'd0)
        else $error("kept box is empty");

    // mid point is corner plus half span
    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_keep |-> {1'b0, o_mid_x} == {1'b0, o_left_x} + {2'b00, o_span_w[11:1]} &&
            {1'b0, o_mid_y} == {1'b0, o_top_y} + {2'b00, o_span_h[11:1]})
        else $error("mid point mismatch");

    // pipeline empties on reset
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind detection_box_decode_filter dbdf_checker u_dbdf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_keep        (o_keep),
    .o_class_index (o_class_index),
    .o_confidence  (o_confidence),
    .o_left_x      (o_left_x),
    .o_top_y       (o_top_y),
    .o_span_w      (o_span_w),
    .o_span_h      (o_span_h),
    .o_mid_x       (o_mid_x),
    .o_mid_y       (o_mid_y)
);

// File: tb/tb.sv
// Testbench for detection_box_decode_filter: streams detections and checks every result item.
`timescale 1ns / 100ps

module tb;
    import dbdf_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd5;

    typedef struct packed {
        logic [COORD_W-1:0]                    centre_x;
        logic [COORD_W-1:0]                    centre_y;
        logic [COORD_W-1:0]                    box_w;
        logic [COORD_W-1:0]                    box_h;
        logic [SCORE_W-1:0]                    objectness;
        logic [NUM_CLASSES-1:0][SCORE_W-1:0]   class_score;
    } t_det_item;

    typedef struct packed {
        logic               keep;
        logic [CLASS_W-1:0] class_index;
        logic [SCORE_W-1:0] confidence;
        logic [PIX_W-1:0]   left_x;
        logic [PIX_W-1:0]   top_y;
        logic [PIX_W-1:0]   span_w;
        logic [PIX_W-1:0]   span_h;
        logic [PIX_W-1:0]   mid_x;
        logic [PIX_W-1:0]   mid_y;
    } t_det_result;

    class t_det_scoreboard;
        logic [SCORE_W-1:0] threshold;
        int                 pad_l;
        int                 pad_t;
        logic [FRAME_W-1:0] frame_w;
        logic [FRAME_W-1:0] frame_h;
        t_det_result        expected_results[$];
        int                 errors;
        int                 checked;

        function new();
            threshold = RST_THRESHOLD;
            pad_l     = 0;
            pad_t     = 0;
            frame_w   = RST_FRAME;
            frame_h   = RST_FRAME;
            errors    = 0;
            checked   = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SCORE_THRESHOLD: threshold = data;
                CFG_PAD_LEFT:        pad_l = int'($signed(data[PAD_W-1:0]));
                CFG_PAD_TOP:         pad_t = int'($signed(data[PAD_W-1:0]));
                CFG_FRAME_WIDTH:     frame_w = data[FRAME_W-1:0];
                CFG_FRAME_HEIGHT:    frame_h = data[FRAME_W-1:0];
                default: ;
            endcase
        endfunction

        // Q.5 domain so that the half size is exact; division truncates toward zero
        function bit span_axis(logic [COORD_W-1:0] centre, logic [COORD_W-1:0] size, int pad,
                               logic [FRAME_W-1:0] frame, output int lo, output int hi);
            int c;
            int s;
            int bound;
            c     = 2 * int'(centre) - 32 * pad;
            s     = int'(size);
            bound = ((frame > FRAME_MAX) ? int'(FRAME_MAX) : int'(frame)) - 1;
            lo    = (c - s) / 32;
            hi    = (c + s) / 32;
            if (lo < 0) lo = 0;
            if (hi > bound) hi = bound;
            return hi > lo;
        endfunction

        function t_det_result decode_detection(t_det_item d);
            t_det_result          r;
            logic [SCORE_W-1:0]   best;
            logic [2*SCORE_W-1:0] prod;
            logic [SCORE_W-1:0]   conf;
            int                   cls;
            int                   x1, x2, y1, y2;
            int                   sw, sh;
            bit                   okx, oky;
            r = '0;
            if (d.objectness < threshold) return r;
            best = d.class_score[0];
            cls  = 0;
            for (int i = 1; i < NUM_CLASSES; i++) begin
                if (d.class_score[i] > best) begin
                    best = d.class_score[i];
                    cls  = i;
                end
            end
            prod = {16'b0, d.objectness} * {16'b0, best};
            conf = prod[2*SCORE_W-1:SCORE_W];
            if (conf < threshold) return r;
            okx = span_axis(d.centre_x, d.box_w, pad_l, frame_w, x1, x2);
            oky = span_axis(d.centre_y, d.box_h, pad_t, frame_h, y1, y2);
            if (!okx || !oky) return r;
            sw            = x2 - x1;
            sh            = y2 - y1;
            r.keep        = 1'b1;
            r.class_index = CLASS_W'(cls);
            r.confidence  = conf;
            r.left_x      = PIX_W'(x1);
            r.top_y       = PIX_W'(y1);
            r.span_w      = PIX_W'(sw);
            r.span_h      = PIX_W'(sh);
            r.mid_x       = PIX_W'(x1 + sw / 2);
            r.mid_y       = PIX_W'(y1 + sh / 2);
            return r;
        endfunction

        function void note_detection(t_det_item d);
            expected_results = {expected_results, decode_detection(d)};
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report(string msg);
            $display("mismatch at result %0d: %s", checked, msg);
            errors++;
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_result(t_det_result got);
            t_det_result want;
            if (expected_results.size() == 0) begin
                report("result item with no detection pending");
                return;
            end
            want = expected_results.pop_front();
            compare_field("keep", 16'(got.keep), 16'(want.keep));
            compare_field("class_index", 16'(got.class_index), 16'(want.class_index));
            compare_field("confidence", got.confidence, want.confidence);
            compare_field("left_x", 16'(got.left_x), 16'(want.left_x));
            compare_field("top_y", 16'(got.top_y), 16'(want.top_y));
            compare_field("span_w", 16'(got.span_w), 16'(want.span_w));
            compare_field("span_h", 16'(got.span_h), 16'(want.span_h));
            compare_field("mid_x", 16'(got.mid_x), 16'(want.mid_x));
            compare_field("mid_y", 16'(got.mid_y), 16'(want.mid_y));
            checked++;
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_centre_x;
    logic [15:0] i_centre_y;
    logic [15:0] i_box_w;
    logic [15:0] i_box_h;
    logic [15:0] i_objectness;
    logic [15:0] i_class_score0;
    logic [15:0] i_class_score1;
    logic [15:0] i_class_score2;
    logic [15:0] i_class_score3;
    logic        o_valid;
    logic        i_ready;
    logic        o_keep;
    logic [1:0]  o_class_index;
    logic [15:0] o_confidence;
    logic [11:0] o_left_x;
    logic [11:0] o_top_y;
    logic [11:0] o_span_w;
    logic [11:0] o_span_h;
    logic [11:0] o_mid_x;
    logic [11:0] o_mid_y;

    t_det_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;

    wire det_accept = i_valid && o_ready;
    wire res_accept = o_valid && i_ready;

    detection_box_decode_filter u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_centre_x     (i_centre_x),
        .i_centre_y     (i_centre_y),
        .i_box_w        (i_box_w),
        .i_box_h        (i_box_h),
        .i_objectness   (i_objectness),
        .i_class_score0 (i_class_score0),
        .i_class_score1 (i_class_score1),
        .i_class_score2 (i_class_score2),
        .i_class_score3 (i_class_score3),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_keep         (o_keep),
        .o_class_index  (o_class_index),
        .o_confidence   (o_confidence),
        .o_left_x       (o_left_x),
        .o_top_y        (o_top_y),
        .o_span_w       (o_span_w),
        .o_span_h       (o_span_h),
        .o_mid_x        (o_mid_x),
        .o_mid_y        (o_mid_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_det_item mk_det(input logic [15:0] cx, cy, w, h, obj, s0, s1, s2, s3);
        t_det_item d;
        d.centre_x       = cx;
        d.centre_y       = cy;
        d.box_w          = w;
        d.box_h          = h;
        d.objectness     = obj;
        d.class_score[0] = s0;
        d.class_score[1] = s1;
        d.class_score[2] = s2;
        d.class_score[3] = s3;
        return d;
    endfunction

    function automatic int usable_frame(logic [FRAME_W-1:0] frame);
        int f;
        f = (frame > FRAME_MAX) ? int'(FRAME_MAX) : int'(frame);
        return (f < 1) ? 1 : f;
    endfunction

    // centre that lands inside the padded frame, in Q12.4
    function automatic logic [COORD_W-1:0] place_coord(int pad, int span);
        int p;
        p = (pad + int'($urandom_range(span))) * 16 + int'($urandom_range(15));
        if (p < 0 || p > 65535) p = int'($urandom_range(65535));
        return COORD_W'(p);
    endfunction

    function automatic t_det_item make_detection();
        t_det_item          d;
        int                 fw, fh, th;
        logic [CLASS_W-1:0] hot, tie;
        th = int'(sb.threshold);
        if ($urandom_range(99) < 25) begin
            d.centre_x   = 16'($urandom);
            d.centre_y   = 16'($urandom);
            d.box_w      = 16'($urandom);
            d.box_h      = 16'($urandom);
            d.objectness = 16'($urandom);
            for (int i = 0; i < NUM_CLASSES; i++) d.class_score[i] = 16'($urandom);
            return d;
        end
        fw         = usable_frame(sb.frame_w);
        fh         = usable_frame(sb.frame_h);
        d.centre_x = place_coord(sb.pad_l, fw);
        d.centre_y = place_coord(sb.pad_t, fh);
        d.box_w    = 16'($urandom_range((fw * 32 > 65535) ? 65535 : fw * 32));
        d.box_h    = 16'($urandom_range((fh * 32 > 65535) ? 65535 : fh * 32));
        d.objectness = ($urandom_range(9) == 0) ? sb.threshold : 16'($urandom_range(65535, th));
        for (int i = 0; i < NUM_CLASSES; i++) d.class_score[i] = 16'($urandom);
        hot = CLASS_W'($urandom_range(NUM_CLASSES - 1));
        d.class_score[hot] = 16'($urandom_range(65535, th));
        if ($urandom_range(3) == 0) begin
            tie = CLASS_W'($urandom_range(NUM_CLASSES - 1));
            d.class_score[tie] = d.class_score[hot];
        end
        return d;
    endfunction

    function automatic logic [15:0] random_pad();
        if ($urandom_range(1) == 0) return 16'($urandom);
        return 16'(int'($urandom_range(128)) - 64);
    endfunction

    function automatic logic [15:0] random_frame();
        if ($urandom_range(1) == 0) return 16'($urandom_range(4096, 1));
        return 16'($urandom);
    endfunction

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_register(idx, data);
    endtask

    task automatic apply_setting(logic [15:0] th, pl, pt, fw, fh);
        write_register(CFG_SCORE_THRESHOLD, th);
        write_register(CFG_PAD_LEFT, pl);
        write_register(CFG_PAD_TOP, pt);
        write_register(CFG_FRAME_WIDTH, fw);
        write_register(CFG_FRAME_HEIGHT, fh);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure_phase(int p);
        case (p)
            0: apply_setting(16'd0, 16'd0, 16'd0, 16'd4096, 16'd4096);
            1: apply_setting(16'hFFFF, 16'h0800, 16'h0800, 16'd1, 16'd1);
            2: apply_setting(16'h1000, 16'h07FF, 16'h07FF, 16'h1FFF, 16'hFFFF);
            3: apply_setting(16'h2000, 16'hF000, 16'h0FFF, 16'd0, 16'd640);
            default: begin
                write_register(CFG_IDX_SPARE, 16'($urandom));
                apply_setting(16'($urandom_range(24000)), random_pad(), random_pad(),
                              random_frame(), random_frame());
            end
        endcase
    endtask

    task automatic send_detection(t_det_item d);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_centre_x     <= d.centre_x;
        i_centre_y     <= d.centre_y;
        i_box_w        <= d.box_w;
        i_box_h        <= d.box_h;
        i_objectness   <= d.objectness;
        i_class_score0 <= d.class_score[0];
        i_class_score1 <= d.class_score[1];
        i_class_score2 <= d.class_score[2];
        i_class_score3 <= d.class_score[3];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_detection(d);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : result_sink
        t_det_result got;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (res_accept) begin
                got.keep        = o_keep;
                got.class_index = o_class_index;
                got.confidence  = o_confidence;
                got.left_x      = o_left_x;
                got.top_y       = o_top_y;
                got.span_w      = o_span_w;
                got.span_h      = o_span_h;
                got.mid_x       = o_mid_x;
                got.mid_y       = o_mid_y;
                sb.check_result(got);
            end
            if (hold_cycles > 0) begin
                i_ready <= 1'b0;
                hold_cycles--;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
            @(posedge i_clk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (det_accept || res_accept) quiet = 0;
            else quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        t_det_item directed[$];
        sb = new();
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= CFG_SCORE_THRESHOLD;
        i_cfg_data     <= '0;
        i_valid        <= 1'b0;
        i_centre_x     <= '0;
        i_centre_y     <= '0;
        i_box_w        <= '0;
        i_box_h        <= '0;
        i_objectness   <= '0;
        i_class_score0 <= '0;
        i_class_score1 <= '0;
        i_class_score2 <= '0;
        i_class_score3 <= '0;

        // reset settings: threshold 0.25, no padding, 640x640
        directed = {directed, mk_det(0, 0, 0, 0, 0, 0, 0, 0, 0)};
        directed = {directed,
                    mk_det(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535)};
        directed = {directed, mk_det(5120, 5120, 1600, 1600, 16383, 65535, 65535, 65535, 65535)};
        directed = {directed, mk_det(5120, 5120, 1600, 1600, 16384, 65535, 0, 0, 0)};
        directed = {directed, mk_det(5120, 5120, 1600, 1600, 32768, 32768, 0, 0, 0)};
        directed = {directed, mk_det(5120, 4000, 1600, 900, 60000, 40000, 40000, 40000, 40000)};
        directed = {directed, mk_det(3000, 6000, 700, 500, 65535, 1000, 2000, 3000, 50000)};
        directed = {directed, mk_det(3000, 6000, 700, 500, 65535, 100, 50000, 50000, 20)};
        directed = {directed, mk_det(3000, 6000, 700, 500, 65535, 0, 0, 60000, 60000)};
        directed = {directed, mk_det(160, 5120, 800, 1600, 65535, 65535, 0, 0, 0)};
        directed = {directed, mk_det(8, 8, 20, 20, 65535, 65535, 0, 0, 0)};
        directed = {directed, mk_det(10080, 5120, 640, 1600, 65535, 65535, 0, 0, 0)};
        directed = {directed, mk_det(11200, 5120, 320, 1600, 65535, 65535, 0, 0, 0)};
        directed = {directed, mk_det(5120, 5120, 0, 1600, 65535, 65535, 0, 0, 0)};
        directed = {directed, mk_det(1602, 5120, 4, 1600, 65535, 65535, 0, 0, 0)};
        directed = {directed, mk_det(65535, 5120, 64, 1600, 65535, 65535, 0, 0, 0)};
        directed = {directed, mk_det(5120, 5120, 1600, 65535, 65535, 65535, 0, 0, 0)};
        directed = {directed, mk_det(1600, 1600, 56, 56, 65535, 65535, 0, 0, 0)};
        directed = {directed, mk_det(10239, 10239, 65535, 65535, 65535, 1, 65535, 2, 3)};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_detection(directed[k]);
        drain_results();

        for (int p = 0; p < 8; p++) begin
            configure_phase(p);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            // long receiver hold-off so the pipeline fills and backs up the input
            if (p == 4) hold_cycles = 300;
            repeat (110) send_detection(make_detection());
            drain_results();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
